>>> hw/rtl/tmr_pkg.sv
// ============================================================================
// tmr_pkg: shared types and constants for the tile-map pixel renderer
// Item layouts, store geometry, view tables and the 16-color palette.
// ============================================================================
package tmr_pkg;

    localparam int MAX_TILES       = 256;
    localparam int MAX_APPEARANCES = 15;
    localparam int SLICE_BYTES     = 156;
    localparam int TILE_PIXELS     = 64;
    localparam int TILE_DEPTH      = MAX_TILES * TILE_PIXELS;
    localparam int MAP_DEPTH       = MAX_APPEARANCES * SLICE_BYTES;
    localparam int TILE_AW         = $clog2(TILE_DEPTH);
    localparam int MAP_AW          = $clog2(MAP_DEPTH);
    localparam int VIEW_COUNT      = 10;
    localparam int APB_AW          = 3;
    localparam int APB_DW          = 32;

    localparam logic [3:0] KEY_COLOR = 4'd13;

    // action codes
    localparam logic [1:0] ACT_TILE   = 2'd0;
    localparam logic [1:0] ACT_MAP    = 2'd1;
    localparam logic [1:0] ACT_RENDER = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_TILE  = 2'd2;

    // register indexes (paddr[2])
    localparam logic REG_TILE_COUNT       = 1'b0;
    localparam logic REG_APPEARANCE_COUNT = 1'b1;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  tile_number;
        logic [5:0]  tile_pixel;
        logic [3:0]  tile_color;
        logic [11:0] map_address;
        logic [7:0]  map_value;
        logic [3:0]  appearance;
        logic [3:0]  view;
        logic [5:0]  column_x;
        logic [6:0]  row_y;
    } in_item_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [1:0] status;
    } out_item_t;

    typedef struct packed {
        logic [8:0] tile_count;
        logic [3:0] appearance_count;
    } cfg_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic tile_read;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic render_ok;
    } dp_stat_t;

    function automatic logic [7:0] view_offset(input logic [3:0] v);
        logic [7:0] r;
        case (v)
            4'd0:    r = 8'd0;
            4'd1:    r = 8'd2;
            4'd2:    r = 8'd6;
            4'd3:    r = 8'd10;
            4'd4:    r = 8'd22;
            4'd5:    r = 8'd38;
            4'd6:    r = 8'd54;
            4'd7:    r = 8'd110;
            4'd8:    r = 8'd132;
            4'd9:    r = 8'd154;
            default: r = 8'd0;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] view_cols(input logic [3:0] v);
        logic [2:0] r;
        case (v)
            4'd0, 4'd1, 4'd2, 4'd9: r = 3'd1;
            4'd3:                   r = 3'd3;
            4'd4, 4'd5, 4'd7, 4'd8: r = 3'd2;
            4'd6:                   r = 3'd7;
            default:                r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] view_rows(input logic [3:0] v);
        logic [3:0] r;
        case (v)
            4'd0, 4'd9:             r = 4'd2;
            4'd1, 4'd2, 4'd3:       r = 4'd4;
            4'd4, 4'd5, 4'd6:       r = 4'd8;
            4'd7, 4'd8:             r = 4'd11;
            default:                r = 4'd0;
        endcase
        return r;
    endfunction

    // {red, green, blue}
    function automatic logic [23:0] ega_rgb(input logic [3:0] c);
        logic [23:0] r;
        case (c)
            4'd0:    r = {8'd0,   8'd0,   8'd0};
            4'd1:    r = {8'd0,   8'd0,   8'd170};
            4'd2:    r = {8'd0,   8'd170, 8'd0};
            4'd3:    r = {8'd0,   8'd170, 8'd170};
            4'd4:    r = {8'd170, 8'd0,   8'd0};
            4'd5:    r = {8'd170, 8'd0,   8'd170};
            4'd6:    r = {8'd170, 8'd85,  8'd0};
            4'd7:    r = {8'd170, 8'd170, 8'd170};
            4'd8:    r = {8'd85,  8'd85,  8'd85};
            4'd9:    r = {8'd85,  8'd85,  8'd255};
            4'd10:   r = {8'd85,  8'd255, 8'd85};
            4'd11:   r = {8'd85,  8'd255, 8'd255};
            4'd12:   r = {8'd255, 8'd85,  8'd85};
            4'd13:   r = {8'd255, 8'd85,  8'd255};
            4'd14:   r = {8'd255, 8'd255, 8'd85};
            default: r = {8'd255, 8'd255, 8'd255};
        endcase
        return r;
    endfunction

endpackage

>>> hw/rtl/tmr_if.sv
// ============================================================================
// tmr_if: item channels of the tile-map pixel renderer
// Valid/ready channels carrying one input item or one result item per beat.
// ============================================================================
interface tmr_in_if import tmr_pkg::*; ();
    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tmr_out_if import tmr_pkg::*; ();
    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/tmr_regs.sv
// ============================================================================
// tmr_regs: configuration registers
// APB-style write/read of tile_count and appearance_count.
// ============================================================================
module tmr_regs import tmr_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [8:0] tile_count_reg;
    logic [3:0] appearance_count_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_count_reg       <= 9'd1;
            appearance_count_reg <= 4'd1;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_TILE_COUNT:       tile_count_reg       <= pwdata[8:0];
                REG_APPEARANCE_COUNT: appearance_count_reg <= pwdata[3:0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_TILE_COUNT:       prdata = {{(APB_DW-9){1'b0}}, tile_count_reg};
            REG_APPEARANCE_COUNT: prdata = {{(APB_DW-4){1'b0}}, appearance_count_reg};
            default:              prdata = '0;
        endcase
    end

    assign cfg.tile_count       = tile_count_reg;
    assign cfg.appearance_count = appearance_count_reg;

endmodule

>>> hw/rtl/tmr_ctrl.sv
// ============================================================================
// tmr_ctrl: item sequencer
// Steps one item through capture, store access and result load, and owns
// the result valid flag.
// ============================================================================
module tmr_ctrl import tmr_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  dp_stat_t  stat,
    output ctrl_cmd_t cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_MAP  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // loads and rejected renders skip the two store reads
                cmd.exec   = 1'b1;
                state_next = stat.render_ok ? S_MAP : S_FIN;
            end
            S_MAP:
            begin
                cmd.tile_read = 1'b1;
                state_next    = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> hw/rtl/tmr_datapath.sv
// ============================================================================
// tmr_datapath: stores, address math and palette
// Holds the tile and map stores, checks coordinates, forms the map and tile
// addresses and builds the result item.
// ============================================================================
module tmr_datapath import tmr_pkg::*; (
    input  logic      clk,
    input  in_item_t  in_data,
    input  cfg_t      cfg,
    input  ctrl_cmd_t cmd,
    output dp_stat_t  stat,
    output out_item_t out_data
);

    logic [3:0] tile_mem [TILE_DEPTH];
    logic [7:0] map_mem  [MAP_DEPTH];

    in_item_t    item_reg;
    logic [7:0]  map_q_reg;
    logic [3:0]  tile_q_reg;
    logic [1:0]  status_reg, status_next;
    logic        zero_tile_reg;
    out_item_t   out_reg, out_next;

    logic [2:0]        cols;
    logic [3:0]        rows;
    logic [5:0]        x_lim;
    logic [6:0]        y_lim;
    logic              coord_ok;
    logic [MAP_AW-1:0] app_base;
    logic [6:0]        row_off;
    logic [MAP_AW-1:0] map_addr;
    logic              render_ok;
    logic              map_wr_ok;
    logic [TILE_AW-1:0] tile_wr_addr;
    logic [TILE_AW-1:0] tile_rd_addr;
    logic [23:0]       rgb;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            item_reg <= in_data;
    end

    assign cols  = view_cols(item_reg.view);
    assign rows  = view_rows(item_reg.view);
    assign x_lim = {cols, 3'b000};
    assign y_lim = {rows, 3'b000};

    assign coord_ok = (item_reg.appearance < cfg.appearance_count)
                   && (item_reg.view < 4'(VIEW_COUNT))
                   && (item_reg.column_x < x_lim)
                   && (item_reg.row_y < y_lim);

    assign app_base = MAP_AW'(item_reg.appearance) * MAP_AW'(SLICE_BYTES);
    assign row_off  = 7'(item_reg.row_y[6:3]) * 7'(cols);
    assign map_addr = app_base + MAP_AW'(view_offset(item_reg.view))
                    + MAP_AW'(row_off) + MAP_AW'(item_reg.column_x[5:3]);

    assign render_ok = (item_reg.action == ACT_RENDER) && coord_ok
                    && (map_addr < MAP_AW'(MAP_DEPTH));
    assign map_wr_ok = item_reg.map_address < MAP_AW'(MAP_DEPTH);

    assign tile_wr_addr = {item_reg.tile_number, item_reg.tile_pixel};
    assign tile_rd_addr = {map_q_reg, item_reg.row_y[2:0], item_reg.column_x[2:0]};

    assign stat.render_ok = render_ok;

    // map store: load writes, render lookup
    always_ff @(posedge clk)
    begin
        if (cmd.exec && (item_reg.action == ACT_MAP) && map_wr_ok)
            map_mem[item_reg.map_address] <= item_reg.map_value;
        if (cmd.exec && render_ok)
            map_q_reg <= map_mem[map_addr];
    end

    // tile store: load writes, pixel fetch from the looked-up tile
    always_ff @(posedge clk)
    begin
        if (cmd.exec && (item_reg.action == ACT_TILE))
            tile_mem[tile_wr_addr] <= item_reg.tile_color;
        if (cmd.tile_read)
            tile_q_reg <= tile_mem[tile_rd_addr];
    end

    always_comb
    begin
        status_next = status_reg;
        if (cmd.exec)
        begin
            unique case (item_reg.action)
                ACT_TILE:   status_next = ST_OK;
                ACT_MAP:    status_next = map_wr_ok ? ST_OK : ST_RANGE;
                ACT_RENDER: status_next = render_ok ? ST_OK : ST_RANGE;
                default:    status_next = ST_RANGE;
            endcase
        end
        else if (cmd.tile_read && ({1'b0, map_q_reg} >= cfg.tile_count))
        begin
            status_next = ST_TILE;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        if (cmd.tile_read)
            zero_tile_reg <= (map_q_reg == 8'd0);
    end

    assign rgb = ega_rgb(tile_q_reg);

    always_comb
    begin
        out_next        = '0;
        out_next.status = status_reg;
        if ((status_reg == ST_OK) && (item_reg.action == ACT_RENDER))
        begin
            out_next.red   = rgb[23:16];
            out_next.green = rgb[15:8];
            out_next.blue  = rgb[7:0];
            out_next.alpha = (zero_tile_reg || (tile_q_reg == KEY_COLOR)) ? 8'd0 : 8'd255;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
            out_reg <= out_next;
    end

    assign out_data = out_reg;

endmodule

>>> hw/rtl/tile_map_pixel_render_core.sv
// ============================================================================
// tile_map_pixel_render_core: tile-map pixel renderer, top level
// Loads tile pixels and map bytes, renders single pixels to EGA RGBA.
// ============================================================================
// One item is in flight at a time. A tile or map load goes from acceptance
// through the exec and finish states to its result beat being offered; a
// render also passes the map state between them: the map store read and the
// tile store read are chained registered reads before the palette lookup
// loads the output register. The next item is accepted right after the
// result is loaded, even while that result still waits for out_ch.ready,
// but never before the result of the last item is loaded. Stores have no
// reset; a render that reads a never-written entry gives unspecified data.
// Configuration: tile_count at 0x0, appearance_count at 0x4, both reset to 1.
module tile_map_pixel_render_core import tmr_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    tmr_in_if.sink            in_ch,
    tmr_out_if.source         out_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    cfg_t      cfg;
    ctrl_cmd_t cmd;
    dp_stat_t  stat;
    logic      in_ready;
    logic      out_valid;
    out_item_t out_data;

    tmr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tmr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    tmr_datapath u_dp (
        .clk      (clk),
        .in_data  (in_ch.data),
        .cfg      (cfg),
        .cmd      (cmd),
        .stat     (stat),
        .out_data (out_data)
    );

    assign in_ch.ready  = in_ready;
    assign out_ch.valid = out_valid;
    assign out_ch.data  = out_data;

endmodule

>>> hw/rtl/tmr_checker.sv
// ============================================================================
// tmr_checker: port-level checks for the tile-map pixel renderer
// Watches the item channels and flags result or sequencing slips.
// ============================================================================
module tmr_checker import tmr_pkg::*; (
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // one item at a time: no accept right after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted on consecutive cycles");

    // any error result carries zero color
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status != ST_OK) |->
            (out_data.red == 8'd0) && (out_data.green == 8'd0)
            && (out_data.blue == 8'd0) && (out_data.alpha == 8'd0))
        else $error("error result with nonzero color");

    a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.alpha == 8'd0) || (out_data.alpha == 8'd255))
        else $error("alpha neither clear nor opaque");

endmodule

bind tile_map_pixel_render_core tmr_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
);

>>> tb/tile_map_pixel_render_core_tb.sv
// ============================================================================
// tile_map_pixel_render_core_tb: self-checking bench for the tile-map renderer
// Loads tiles and map bytes, renders pixels under several register settings
// and checks each result beat against an in-bench model of the stores.
// ============================================================================
module tile_map_pixel_render_core_tb;
    import tmr_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [1:0] ACT_SPARE = 2'd3;

    localparam logic [7:0] VIEW_BASE [VIEW_COUNT] = '{0, 2, 6, 10, 22, 38, 54, 110, 132, 154};
    localparam int VIEW_W [VIEW_COUNT] = '{1, 1, 1, 3, 2, 2, 7, 2, 2, 1};
    localparam int VIEW_H [VIEW_COUNT] = '{2, 4, 4, 4, 8, 8, 8, 11, 11, 2};
    // {red, green, blue}
    localparam logic [23:0] PALETTE [16] = '{
        24'h000000, 24'h0000AA, 24'h00AA00, 24'h00AAAA,
        24'hAA0000, 24'hAA00AA, 24'hAA5500, 24'hAAAAAA,
        24'h555555, 24'h5555FF, 24'h55FF55, 24'h55FFFF,
        24'hFF5555, 24'hFF55FF, 24'hFFFF55, 24'hFFFFFF
    };

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic pready;

    tmr_in_if  in_ch ();
    tmr_out_if out_ch ();

    tile_map_pixel_render_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 clk = ~clk;

    // model state, updated on accepted beats
    logic [3:0] tile_pix  [TILE_DEPTH];
    logic [7:0] map_bytes [MAP_DEPTH];
    logic [8:0] cfg_tiles = 9'd1;
    logic [3:0] cfg_apps  = 4'd1;

    // what the stimulus has already written (keeps renders off unwritten entries)
    bit         map_set    [MAP_DEPTH];
    logic [7:0] map_shadow [MAP_DEPTH];
    bit         pix_set    [TILE_DEPTH];

    in_item_t  pending_items [$];
    out_item_t expected_pixels [$];

    int unsigned mismatches = 0;
    int unsigned idle_cycles = 0;
    int unsigned send_gap = 0;
    int unsigned hold_left = 0;
    bit steady = 1'b0;

    function automatic int tile_limit(logic [8:0] c);
        return (c > MAX_TILES) ? MAX_TILES : int'(c);
    endfunction

    // map byte address of a render, -1 when the coordinates are rejected
    function automatic int map_index(in_item_t it, logic [3:0] apps);
        int v;
        int a;
        v = it.view;
        if (it.appearance >= apps || v >= VIEW_COUNT)
            return -1;
        if (it.column_x >= VIEW_W[v] * 8 || it.row_y >= VIEW_H[v] * 8)
            return -1;
        a = it.appearance * SLICE_BYTES + VIEW_BASE[v] + (it.row_y >> 3) * VIEW_W[v]
            + (it.column_x >> 3);
        return (a >= MAP_DEPTH) ? -1 : a;
    endfunction

    function automatic out_item_t apply_item(in_item_t it);
        out_item_t r;
        int a;
        logic [7:0] num;
        logic [3:0] col;
        r = '0;
        r.status = ST_RANGE;
        case (it.action)
            ACT_TILE:
            begin
                tile_pix[{it.tile_number, it.tile_pixel}] = it.tile_color;
                r.status = ST_OK;
            end
            ACT_MAP:
            begin
                if (it.map_address < MAP_DEPTH)
                begin
                    map_bytes[it.map_address] = it.map_value;
                    r.status = ST_OK;
                end
            end
            ACT_RENDER:
            begin
                a = map_index(it, cfg_apps);
                if (a >= 0)
                begin
                    num = map_bytes[a];
                    if (num >= tile_limit(cfg_tiles))
                        r.status = ST_TILE;
                    else
                    begin
                        col = tile_pix[{num, it.row_y[2:0], it.column_x[2:0]}];
                        {r.red, r.green, r.blue} = PALETTE[col];
                        r.alpha = (num == 0 || col == KEY_COLOR) ? 8'd0 : 8'd255;
                        r.status = ST_OK;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic in_item_t random_bits();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(in_item_t)-1:0];
    endfunction

    function automatic logic [7:0] pick_map_value();
        int r;
        int lim;
        r = $urandom_range(0, 99);
        lim = tile_limit(cfg_tiles);
        if (r < 45)
            return 8'($urandom_range(0, 7));
        if (r < 85 && lim > 0)
            return 8'($urandom_range(0, lim - 1));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic in_item_t tile_beat(int n, int p, int c);
        in_item_t it;
        it = random_bits();
        it.action = ACT_TILE;
        it.tile_number = 8'(n);
        it.tile_pixel = 6'(p);
        it.tile_color = 4'(c);
        return it;
    endfunction

    function automatic in_item_t map_beat(int a, int v);
        in_item_t it;
        it = random_bits();
        it.action = ACT_MAP;
        it.map_address = 12'(a);
        it.map_value = 8'(v);
        return it;
    endfunction

    function automatic in_item_t render_beat(int app, int v, int x, int y);
        in_item_t it;
        it = random_bits();
        it.action = ACT_RENDER;
        it.appearance = 4'(app);
        it.view = 4'(v);
        it.column_x = 6'(x);
        it.row_y = 7'(y);
        return it;
    endfunction

    // renders that will read the stores get their map byte and tile pixel loaded first
    task automatic queue_item(in_item_t it);
        int a;
        logic [7:0] num;
        if (it.action == ACT_RENDER)
        begin
            a = map_index(it, cfg_apps);
            if (a >= 0)
            begin
                if (!map_set[a])
                    queue_item(map_beat(a, pick_map_value()));
                num = map_shadow[a];
                if (num < tile_limit(cfg_tiles) && !pix_set[{num, it.row_y[2:0], it.column_x[2:0]}])
                    queue_item(tile_beat(num, {it.row_y[2:0], it.column_x[2:0]},
                                         $urandom_range(0, 15)));
            end
        end
        else if (it.action == ACT_TILE)
            pix_set[{it.tile_number, it.tile_pixel}] = 1'b1;
        else if (it.action == ACT_MAP && it.map_address < MAP_DEPTH)
        begin
            map_set[it.map_address] = 1'b1;
            map_shadow[it.map_address] = it.map_value;
        end
        pending_items.push_back(it);
    endtask

    task automatic queue_random();
        in_item_t it;
        int r;
        it = random_bits();
        r = $urandom_range(0, 99);
        if (r < 14)
            it.action = ACT_TILE;
        else if (r < 28)
        begin
            it.action = ACT_MAP;
            if ($urandom_range(0, 9) < 9)
                it.map_address = 12'($urandom_range(0, MAP_DEPTH - 1));
            else
                it.map_address = 12'($urandom_range(MAP_DEPTH, 4095));
            it.map_value = pick_map_value();
        end
        else if (r < 31)
            it.action = ACT_SPARE;
        else
        begin
            it.action = ACT_RENDER;
            // mostly coordinates inside a loaded view, the rest raw noise
            if ($urandom_range(0, 9) < 8)
            begin
                it.appearance = (cfg_apps == 0) ? 4'd0 : 4'($urandom_range(0, cfg_apps - 1));
                it.view = 4'($urandom_range(0, VIEW_COUNT - 1));
                it.column_x = 6'($urandom_range(0, VIEW_W[it.view] * 8 - 1));
                it.row_y = 7'($urandom_range(0, VIEW_H[it.view] * 8 - 1));
            end
        end
        queue_item(it);
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || in_ch.valid || expected_pixels.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(logic reg_sel, logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == REG_TILE_COUNT)
            cfg_tiles = value[8:0];
        else
            cfg_apps = value[3:0];
    endtask

    task automatic set_config(int tiles, int apps);
        drain();
        repeat (6) @(posedge clk);
        write_reg(REG_TILE_COUNT, tiles);
        write_reg(REG_APPEARANCE_COUNT, apps);
    endtask

    // input driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.data  <= '0;
            send_gap = 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                void'(pending_items.pop_front());
                send_gap = steady ? 0 : pick_gap();
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (send_gap == 0 && pending_items.size() > 0)
                begin
                    in_ch.valid <= 1'b1;
                    in_ch.data  <= pending_items[0];
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                    if (send_gap > 0)
                        send_gap--;
                end
            end
        end
    end

    // result sink with random backpressure
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            hold_left = 0;
        end
        else if (hold_left > 0)
        begin
            out_ch.ready <= 1'b0;
            hold_left--;
        end
        else
        begin
            out_ch.ready <= 1'b1;
            if (!steady && $urandom_range(0, 9) < 2)
                hold_left = pick_gap();
        end
    end

    // monitor and checker
    always @(posedge clk)
    begin
        out_item_t want;
        out_item_t got;
        bit beat;
        if (rst_n)
        begin
            beat = 1'b0;
            if (in_ch.valid && in_ch.ready)
            begin
                expected_pixels.push_back(apply_item(in_ch.data));
                beat = 1'b1;
            end
            if (out_ch.valid && out_ch.ready)
            begin
                beat = 1'b1;
                got = out_ch.data;
                if (expected_pixels.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: r=%0d g=%0d b=%0d a=%0d st=%0d",
                                 got.red, got.green, got.blue, got.alpha, got.status);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue || got.alpha !== want.alpha ||
                        got.status !== want.status)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp r=%0d g=%0d b=%0d a=%0d st=%0d, got r=%0d g=%0d b=%0d a=%0d st=%0d",
                                     want.red, want.green, want.blue, want.alpha, want.status,
                                     got.red, got.green, got.blue, got.alpha, got.status);
                    end
                end
            end
            idle_cycles = beat ? 0 : idle_cycles + 1;
        end
    end

    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        int n;
        in_item_t spare;
        rst_n   <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset settings: one tile, one appearance
        queue_item(tile_beat(0, 0, 0));
        queue_item(tile_beat(255, 63, 15));
        queue_item(tile_beat(0, 63, 13));
        queue_item(map_beat(0, 0));
        queue_item(map_beat(MAP_DEPTH - 1, 255));
        queue_item(map_beat(MAP_DEPTH, 7));
        queue_item(map_beat(4095, 0));
        spare = random_bits();
        spare.action = ACT_SPARE;
        queue_item(spare);
        queue_item(render_beat(0, 0, 0, 0));
        queue_item(render_beat(0, 0, 7, 15));
        queue_item(render_beat(1, 0, 0, 0));
        queue_item(render_beat(15, 0, 0, 0));
        queue_item(render_beat(0, 10, 0, 0));
        queue_item(render_beat(0, 15, 63, 127));
        queue_item(render_beat(0, 0, 8, 0));
        queue_item(render_beat(0, 0, 0, 16));
        queue_item(map_beat(2, 255));
        queue_item(render_beat(0, 1, 0, 0));

        // directed, full settings: key color, far corners, top tile
        set_config(MAX_TILES, MAX_APPEARANCES);
        queue_item(tile_beat(5, 9, 13));
        queue_item(map_beat(14 * SLICE_BYTES + 54, 5));
        queue_item(render_beat(14, 6, 1, 1));
        queue_item(tile_beat(5, 10, 12));
        queue_item(render_beat(14, 6, 2, 1));
        queue_item(render_beat(14, 9, 7, 15));
        queue_item(render_beat(0, 6, 55, 63));
        queue_item(render_beat(0, 7, 15, 87));
        queue_item(render_beat(14, 8, 15, 88));
        queue_item(tile_beat(255, 0, 1));
        queue_item(map_beat(100, 255));
        queue_item(render_beat(0, 6, 32, 48));

        for (int ph = 0; ph < 7; ph++)
        begin
            case (ph)
                0: set_config(MAX_TILES, MAX_APPEARANCES);
                1: set_config(1, 1);
                2: set_config(0, MAX_APPEARANCES);
                3: set_config(511, 0);
                6: set_config(MAX_TILES, MAX_APPEARANCES);
                default: set_config($urandom_range(2, MAX_TILES), $urandom_range(1, MAX_APPEARANCES));
            endcase
            steady = (ph == 1 || ph == 4);
            n = (ph == 3) ? 40 : (ph == 1 || ph == 2) ? 90 : 220;
            for (int k = 0; k < n; k++)
            begin
                // sender holds off mid-phase until the block has emptied
                if (ph == 6 && k == n / 2)
                    drain();
                queue_random();
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && expected_pixels.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
